// ===== sv/tts_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tts_pkg
// Shared types, command codes and character translation for the text
// terminal screen buffer.
// ----------------------------------------------------------------------------
package tts_pkg;

  typedef logic [2:0] opcode_t;

  localparam opcode_t OP_CLEAR     = 3'd0;
  localparam opcode_t OP_SET_COL   = 3'd1;
  localparam opcode_t OP_SET_ROW   = 3'd2;
  localparam opcode_t OP_SET_SHOWN = 3'd3;
  localparam opcode_t OP_PUT       = 3'd4;
  localparam opcode_t OP_GET       = 3'd5;

  // Field widths fixed by the command and result formats
  localparam int CHAR_W   = 8;
  localparam int POS_W    = 8;
  localparam int OUT_COL_W = 6;
  localparam int OUT_ROW_W = 5;
  // Linear index math: 8-bit row times a column count below 256
  localparam int IDX_W    = 16;

  localparam logic [CHAR_W-1:0] SPACE_CODE = 8'h20;

  // ASCII to screen code
  function automatic logic [CHAR_W-1:0] to_screen(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] r;
    if (c >= 8'h60) begin
      r = c - 8'h60;
    end else if (c >= 8'h40) begin
      r = c - 8'h40;
    end else begin
      r = c;
    end
    return r;
  endfunction

  // Screen code back to ASCII
  function automatic logic [CHAR_W-1:0] to_ascii(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] r;
    if (c < 8'h20) begin
      r = c + 8'h40;
    end else begin
      r = c;
    end
    return r;
  endfunction

endpackage

// ===== sv/tts_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tts_if
// Valid/ready channel interfaces for commands and results.
// ----------------------------------------------------------------------------
interface tts_cmd_if;
  logic                       valid;
  logic                       ready;
  tts_pkg::opcode_t           opcode;
  logic [tts_pkg::CHAR_W-1:0] char_or_pos;
  logic [tts_pkg::POS_W-1:0]  read_col;
  logic [tts_pkg::POS_W-1:0]  read_row;

  modport source (output valid, output opcode, output char_or_pos,
                  output read_col, output read_row, input ready);
  modport sink   (input valid, input opcode, input char_or_pos,
                  input read_col, input read_row, output ready);
endinterface

interface tts_res_if;
  logic                          valid;
  logic                          ready;
  logic [tts_pkg::CHAR_W-1:0]    read_char;
  logic [tts_pkg::OUT_COL_W-1:0] cursor_col;
  logic [tts_pkg::OUT_ROW_W-1:0] cursor_row;
  logic                          cursor_shown;
  logic                          status;

  modport source (output valid, output read_char, output cursor_col,
                  output cursor_row, output cursor_shown, output status,
                  input ready);
  modport sink   (input valid, input read_char, input cursor_col,
                  input cursor_row, input cursor_shown, input status,
                  output ready);
endinterface

// ===== sv/tts_cell_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tts_cell_ram
// Character cell store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tts_cell_ram #(
  parameter int DEPTH = 1000,
  parameter int AW    = 10
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic [tts_pkg::CHAR_W-1:0] wdata,
  input  logic                       re,
  input  logic [AW-1:0]              raddr,
  output logic [tts_pkg::CHAR_W-1:0] rdata
);

  logic [tts_pkg::CHAR_W-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/tts_clear_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tts_clear_seq
// Walks every cell address once, after reset and after a clear command.
// ----------------------------------------------------------------------------
module tts_clear_seq #(
  parameter int DEPTH = 1000,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  output logic [AW-1:0] addr
);

  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  // Sweep counter; busy drops after the last cell is written
  always_ff @(posedge clk) begin
    if (rst || start) begin
      busy <= 1'b1;
      addr <= '0;
    end else if (busy) begin
      if (addr == LAST) begin
        busy <= 1'b0;
      end else begin
        addr <= addr + 1'b1;
      end
    end
  end

endmodule

// ===== sv/text_terminal_screen_buffer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_terminal_screen_buffer_core
// COLUMNS x ROWS character screen store with cursor, one command per transfer.
// ----------------------------------------------------------------------------
// Usage:
//   cmd carries one command per transfer (clear, set column, set row, set
//   cursor shown, put char, get char). res returns exactly one result per
//   command with the cursor after the command, the read character for a
//   get, and an out-of-screen flag.
//   Latency: the result is valid the cycle after the command transfer.
//   Throughput: one command per cycle when not held by a sweep or a stalled
//   result; cell reads and writes use the single read and write port of the
//   cell memory, one access each per command.
//   Clear: the cursor is homed at once and its result goes out, then the cell
//   memory is swept one cell per cycle, with cmd.ready low throughout.
//   Reset: cursor and flags return to zero and the same sweep runs, so cmd
//   is not ready until that sweep ends after reset is released.
//   Receiver stall: one output register holds the result; while it is
//   full and res.ready is low, cmd.ready is low.
// ----------------------------------------------------------------------------
module text_terminal_screen_buffer_core #(
  parameter int COLUMNS = 40,
  parameter int ROWS    = 25
) (
  input  logic       clk,
  input  logic       rst,
  tts_cmd_if.sink    cmd,
  tts_res_if.source  res
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int CW    = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int TAB_N = 1 << tts_pkg::POS_W;

  localparam logic [CW-1:0] COL_LAST = CW'(COLUMNS - 1);
  localparam logic [RW-1:0] ROW_LAST = RW'(ROWS - 1);

  // Cursor state
  logic [CW-1:0] cur_col, cur_col_next;
  logic [RW-1:0] cur_row, cur_row_next;
  logic          shown, shown_next;

  // Output register
  logic                          out_valid;
  logic [tts_pkg::OUT_COL_W-1:0] out_col;
  logic [tts_pkg::OUT_ROW_W-1:0] out_row;
  logic                          out_shown;
  logic                          out_status;
  logic                          out_get;

  logic                          accept;
  logic                          is_put, is_get, get_ok;
  logic [tts_pkg::IDX_W-1:0]     put_lin, get_lin;
  logic                          clr_busy;
  logic [AW-1:0]                 clr_addr;
  logic                          ram_we;
  logic [AW-1:0]                 ram_waddr;
  logic [tts_pkg::CHAR_W-1:0]    ram_wdata;
  logic [tts_pkg::CHAR_W-1:0]    ram_rdata;

  // Position modulo tables, built at elaboration
  logic [CW-1:0] col_mod [TAB_N];
  logic [RW-1:0] row_mod [TAB_N];

  for (genvar i = 0; i < TAB_N; i++) begin : g_mod
    assign col_mod[i] = CW'(i % COLUMNS);
    assign row_mod[i] = RW'(i % ROWS);
  end

  assign cmd.ready = !clr_busy && (!out_valid || res.ready);
  assign accept    = cmd.valid && cmd.ready;
  assign is_put    = (cmd.opcode == tts_pkg::OP_PUT);
  assign is_get    = (cmd.opcode == tts_pkg::OP_GET);

  // Get bounds and linear cell indexes
  assign get_ok  = ({1'b0, cmd.read_col} < 9'(COLUMNS))
                && ({1'b0, cmd.read_row} < 9'(ROWS));
  assign get_lin = tts_pkg::IDX_W'(cmd.read_row) * tts_pkg::IDX_W'(COLUMNS)
                 + tts_pkg::IDX_W'(cmd.read_col);
  assign put_lin = tts_pkg::IDX_W'(cur_row) * tts_pkg::IDX_W'(COLUMNS)
                 + tts_pkg::IDX_W'(cur_col);

  // Cursor update per command
  always_comb begin
    cur_col_next = cur_col;
    cur_row_next = cur_row;
    shown_next   = shown;
    case (cmd.opcode)
      tts_pkg::OP_CLEAR: begin
        cur_col_next = '0;
        cur_row_next = '0;
      end
      tts_pkg::OP_SET_COL:   cur_col_next = col_mod[cmd.char_or_pos];
      tts_pkg::OP_SET_ROW:   cur_row_next = row_mod[cmd.char_or_pos];
      tts_pkg::OP_SET_SHOWN: shown_next = (cmd.char_or_pos == '0);
      tts_pkg::OP_PUT: begin
        if (cur_col == COL_LAST) begin
          cur_col_next = '0;
          cur_row_next = (cur_row == ROW_LAST) ? '0 : cur_row + 1'b1;
        end else begin
          cur_col_next = cur_col + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_col <= '0;
      cur_row <= '0;
      shown   <= 1'b0;
    end else if (accept) begin
      cur_col <= cur_col_next;
      cur_row <= cur_row_next;
      shown   <= shown_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_col    <= tts_pkg::OUT_COL_W'(cur_col_next);
      out_row    <= tts_pkg::OUT_ROW_W'(cur_row_next);
      out_shown  <= shown_next;
      out_status <= is_get && !get_ok;
      out_get    <= is_get && get_ok;
    end
  end

  // Clear sweep
  tts_clear_seq #(
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_clear (
    .clk   (clk),
    .rst   (rst),
    .start (accept && (cmd.opcode == tts_pkg::OP_CLEAR)),
    .busy  (clr_busy),
    .addr  (clr_addr)
  );

  // Memory write: sweep has the port while busy, else a put
  assign ram_we    = clr_busy || (accept && is_put);
  assign ram_waddr = clr_busy ? clr_addr : put_lin[AW-1:0];
  assign ram_wdata = clr_busy ? tts_pkg::SPACE_CODE : tts_pkg::to_screen(cmd.char_or_pos);

  tts_cell_ram #(
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept && is_get && get_ok),
    .raddr (get_lin[AW-1:0]),
    .rdata (ram_rdata)
  );

  // Result channel
  assign res.valid        = out_valid;
  assign res.read_char    = out_get ? tts_pkg::to_ascii(ram_rdata) : '0;
  assign res.cursor_col   = out_col;
  assign res.cursor_row   = out_row;
  assign res.cursor_shown = out_shown;
  assign res.status       = out_status;

endmodule

// ===== sv/tts_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tts_checker
// Port-level checks for the screen buffer, bound to the top level.
// ----------------------------------------------------------------------------
module tts_checker #(
  parameter int COLUMNS = 40,
  parameter int ROWS    = 25
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          cmd_valid,
  input logic                          cmd_ready,
  input tts_pkg::opcode_t              cmd_opcode,
  input logic                          res_valid,
  input logic                          res_ready,
  input logic [tts_pkg::CHAR_W-1:0]    res_read_char,
  input logic [tts_pkg::OUT_COL_W-1:0] res_cursor_col,
  input logic [tts_pkg::OUT_ROW_W-1:0] res_cursor_row,
  input logic                          res_status
);

  // Stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_read_char)
      && $stable(res_cursor_col) && $stable(res_cursor_row) && $stable(res_status))
    else $error("result changed while stalled");

  // Reported cursor stays on screen
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> ({3'b0, res_cursor_col} < 9'(COLUMNS))
      && ({4'b0, res_cursor_row} < 9'(ROWS)))
    else $error("cursor off screen");

  // Out-of-screen get returns zero
  a_status_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_status |-> res_read_char == '0)
    else $error("flagged get returned data");

  // Sweep after reset blocks intake
  a_reset_sweep: assert property (@(posedge clk)
    $fell(rst) |-> !cmd_ready)
    else $error("command taken during reset sweep");

  // Clear starts a sweep that blocks intake
  a_clear_sweep: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready && cmd_opcode == tts_pkg::OP_CLEAR |=> !cmd_ready)
    else $error("command taken during clear sweep");

endmodule

bind text_terminal_screen_buffer_core tts_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_tts_checker (
  .clk            (clk),
  .rst            (rst),
  .cmd_valid      (cmd.valid),
  .cmd_ready      (cmd.ready),
  .cmd_opcode     (cmd.opcode),
  .res_valid      (res.valid),
  .res_ready      (res.ready),
  .res_read_char  (res.read_char),
  .res_cursor_col (res.cursor_col),
  .res_cursor_row (res.cursor_row),
  .res_status     (res.status)
);

// ===== bench/text_terminal_screen_buffer_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_terminal_screen_buffer_core_tb
// Self-checking bench for the 40x25 text screen store. Commands go in on the
// cmd channel and each one is run through a local screen and cursor model;
// the model's report is queued and compared field by field with what comes
// out on res. The run covers directed corner cases, long random typing
// sessions with readback, noise, a long receiver hold-off and a final
// back-to-back stream.
// ----------------------------------------------------------------------------
module text_terminal_screen_buffer_core_tb;

  localparam int SCR_COLS   = 40;
  localparam int SCR_ROWS   = 25;
  localparam int SCR_CELLS  = SCR_COLS * SCR_ROWS;
  localparam int QUIET_MAX  = 5000;   // cycles with no transfer before giving up
  localparam int HOLD_LEN   = 80;     // long receiver hold-off
  localparam int RANDOM_CMDS = 1070;

  // Opcodes the block decodes as no-ops
  localparam tts_pkg::opcode_t OP_SPARE_6 = 3'd6;
  localparam tts_pkg::opcode_t OP_SPARE_7 = 3'd7;

  typedef struct packed {
    tts_pkg::opcode_t opcode;
    logic [7:0]       char_or_pos;
    logic [7:0]       read_col;
    logic [7:0]       read_row;
  } command_t;

  typedef struct packed {
    logic [7:0] read_char;
    logic [5:0] cursor_col;
    logic [4:0] cursor_row;
    logic       cursor_shown;
    logic       status;
  } report_t;

  logic clk = 1'b0;
  logic rst;

  tts_cmd_if cmd_ch ();
  tts_res_if res_ch ();

  text_terminal_screen_buffer_core #(
    .COLUMNS (SCR_COLS),
    .ROWS    (SCR_ROWS)
  ) i_dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .res (res_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Screen model: cell codes, cursor and cursor visibility
  logic [7:0] screen_image [SCR_CELLS];
  int unsigned cur_x;
  int unsigned cur_y;
  logic        shown_now;

  report_t due_reports [$];

  bit src_idle_en;
  bit sink_idle_en;
  bit long_hold_req;

  int unsigned sent_cmds;
  int unsigned checked;
  int unsigned faults;
  int unsigned n_puts, n_gets, n_offscreen, n_clears, n_line_wraps, n_top_wraps;
  int unsigned n_holds;
  int unsigned quiet_cycles;

  // ASCII to screen code
  function automatic logic [7:0] glyph_of(input logic [7:0] ch);
    case (ch[7:5])
      3'b000, 3'b001: glyph_of = ch;
      3'b010:         glyph_of = ch - 8'h40;
      default:        glyph_of = ch - 8'h60;
    endcase
  endfunction

  // Screen code to ASCII
  function automatic logic [7:0] char_of(input logic [7:0] code);
    char_of = (code[7:5] == 3'b000) ? (code | 8'h40) : code;
  endfunction

  // Run one command through the screen model and return its report
  function automatic report_t advance_screen(input command_t c);
    report_t r;
    r = '0;
    case (c.opcode)
      tts_pkg::OP_CLEAR: begin
        foreach (screen_image[i]) screen_image[i] = tts_pkg::SPACE_CODE;
        cur_x = 0;
        cur_y = 0;
        n_clears++;
      end
      tts_pkg::OP_SET_COL:   cur_x = c.char_or_pos % SCR_COLS;
      tts_pkg::OP_SET_ROW:   cur_y = c.char_or_pos % SCR_ROWS;
      tts_pkg::OP_SET_SHOWN: shown_now = (c.char_or_pos == 8'd0);
      tts_pkg::OP_PUT: begin
        screen_image[cur_y * SCR_COLS + cur_x] = glyph_of(c.char_or_pos);
        n_puts++;
        if (cur_x == SCR_COLS - 1) begin
          cur_x = 0;
          if (cur_y == SCR_ROWS - 1) begin
            cur_y = 0;
            n_top_wraps++;
          end else begin
            cur_y++;
            n_line_wraps++;
          end
        end else begin
          cur_x++;
        end
      end
      tts_pkg::OP_GET: begin
        n_gets++;
        if (c.read_col < SCR_COLS && c.read_row < SCR_ROWS) begin
          r.read_char = char_of(screen_image[c.read_row * SCR_COLS + c.read_col]);
        end else begin
          r.status = 1'b1;
          n_offscreen++;
        end
      end
      default: ;
    endcase
    r.cursor_col   = 6'(cur_x);
    r.cursor_row   = 5'(cur_y);
    r.cursor_shown = shown_now;
    return r;
  endfunction

  // Offer one command and wait for its transfer; valid stays up afterwards
  task automatic issue(input tts_pkg::opcode_t op, input int unsigned val,
                       input int unsigned rc, input int unsigned rr);
    command_t c;
    if (src_idle_en && $urandom_range(0, 4) == 0) begin
      cmd_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    c = '{op, 8'(val), 8'(rc), 8'(rr)};
    cmd_ch.valid       <= 1'b1;
    cmd_ch.opcode      <= op;
    cmd_ch.char_or_pos <= 8'(val);
    cmd_ch.read_col    <= 8'(rc);
    cmd_ch.read_row    <= 8'(rr);
    do @(posedge clk); while (!cmd_ch.ready);
    due_reports.push_back(advance_screen(c));
    sent_cmds++;
  endtask

  // Stop offering and wait for every outstanding result
  task automatic drain_reports();
    cmd_ch.valid <= 1'b0;
    do @(posedge clk); while (due_reports.size() != 0);
  endtask

  // Results checker
  always @(posedge clk) begin : check_results
    report_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (due_reports.size() == 0) begin
        $error("result transfer with no command outstanding");
        faults++;
      end else begin
        want = due_reports.pop_front();
        checked++;
        if (res_ch.read_char !== want.read_char) begin
          $error("read_char: expected %0h, actual %0h", want.read_char, res_ch.read_char);
          faults++;
        end
        if (res_ch.cursor_col !== want.cursor_col) begin
          $error("cursor_col: expected %0d, actual %0d", want.cursor_col, res_ch.cursor_col);
          faults++;
        end
        if (res_ch.cursor_row !== want.cursor_row) begin
          $error("cursor_row: expected %0d, actual %0d", want.cursor_row, res_ch.cursor_row);
          faults++;
        end
        if (res_ch.cursor_shown !== want.cursor_shown) begin
          $error("cursor_shown: expected %0b, actual %0b", want.cursor_shown,
                 res_ch.cursor_shown);
          faults++;
        end
        if (res_ch.status !== want.status) begin
          $error("status: expected %0b, actual %0b", want.status, res_ch.status);
          faults++;
        end
      end
    end
  end

  // Receiver: random stall bursts, plus one long hold-off on request
  initial begin : result_sink
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        res_ch.ready <= 1'b0;
        for (int n = 0; n < HOLD_LEN; n++) @(posedge clk);
        res_ch.ready <= 1'b1;
        n_holds++;
      end else if (sink_idle_en && $urandom_range(0, 6) == 0) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        res_ch.ready <= 1'b1;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog on stretches with no transfer on either channel
  always @(posedge clk) begin
    if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_MAX) begin
      $display("Timeout: no transfer for %0d cycles, %0d results outstanding",
               QUIET_MAX, due_reports.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Fresh store reads as spaces, including the far corner
  task automatic test_after_reset();
    issue(tts_pkg::OP_GET, $urandom, 8'd0, 8'd0);
    issue(tts_pkg::OP_GET, $urandom, 8'd39, 8'd24);
  endtask

  // Cursor positions wrap modulo the screen size; shown only for value zero
  task automatic test_cursor_setup();
    issue(tts_pkg::OP_SET_COL, 8'd255, $urandom, $urandom);
    issue(tts_pkg::OP_SET_ROW, 8'd255, $urandom, $urandom);
    issue(tts_pkg::OP_SET_COL, 8'd40, $urandom, $urandom);
    issue(tts_pkg::OP_SET_ROW, 8'd25, $urandom, $urandom);
    issue(tts_pkg::OP_SET_SHOWN, 8'd0, $urandom, $urandom);
    issue(tts_pkg::OP_SET_SHOWN, 8'd255, $urandom, $urandom);
    issue(tts_pkg::OP_SET_SHOWN, 8'd0, $urandom, $urandom);
  endtask

  // Translation bands on the way in and out, at row 0
  task automatic test_translation();
    issue(tts_pkg::OP_PUT, 8'h00, $urandom, $urandom);
    issue(tts_pkg::OP_PUT, 8'h3F, $urandom, $urandom);
    issue(tts_pkg::OP_PUT, 8'h40, $urandom, $urandom);
    issue(tts_pkg::OP_PUT, 8'h60, $urandom, $urandom);
    issue(tts_pkg::OP_PUT, 8'hFF, $urandom, $urandom);
    issue(tts_pkg::OP_GET, $urandom, 8'd0, 8'd0);
    issue(tts_pkg::OP_GET, $urandom, 8'd4, 8'd0);
  endtask

  // Put in the bottom right cell sends the cursor back to the top
  task automatic test_wrap_to_top();
    issue(tts_pkg::OP_SET_COL, 8'd39, $urandom, $urandom);
    issue(tts_pkg::OP_SET_ROW, 8'd24, $urandom, $urandom);
    issue(tts_pkg::OP_PUT, 8'h5F, $urandom, $urandom);
    issue(tts_pkg::OP_GET, $urandom, 8'd39, 8'd24);
  endtask

  // Off-screen reads and the spare opcodes
  task automatic test_offscreen_and_spare();
    issue(tts_pkg::OP_GET, $urandom, 8'd40, 8'd0);
    issue(tts_pkg::OP_GET, $urandom, 8'd0, 8'd25);
    issue(OP_SPARE_6, 8'hFF, 8'hFF, 8'hFF);
    issue(OP_SPARE_7, 8'h00, 8'h00, 8'h00);
  endtask

  // Clear homes the cursor, keeps the shown flag and blanks the cells
  task automatic test_clear();
    issue(tts_pkg::OP_CLEAR, $urandom, $urandom, $urandom);
    issue(tts_pkg::OP_GET, $urandom, 8'd39, 8'd24);
  endtask

  // Random typing sessions with readback, mixed with noise and clears
  task automatic test_random_sessions(input int unsigned target);
    int unsigned pick;
    int unsigned burst;
    int unsigned back_x;
    int unsigned back_y;
    while (sent_cmds < target) begin
      if ($urandom_range(0, 9) == 0) begin
        src_idle_en  = $urandom_range(0, 1);
        sink_idle_en = $urandom_range(0, 1);
      end
      pick = $urandom_range(0, 19);
      if ($urandom_range(0, 59) == 0) begin
        issue(tts_pkg::OP_CLEAR, $urandom, $urandom, $urandom);
      end else if (pick < 14) begin
        // Position, type a run of characters, then read some back
        issue(tts_pkg::OP_SET_ROW,
              ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                          : $urandom_range(0, SCR_ROWS - 1),
              $urandom, $urandom);
        issue(tts_pkg::OP_SET_COL,
              ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                          : $urandom_range(0, SCR_COLS - 1),
              $urandom, $urandom);
        burst = $urandom_range(1, 45);
        repeat (burst) issue(tts_pkg::OP_PUT, $urandom_range(0, 255), $urandom, $urandom);
        back_x = (cur_x == 0) ? SCR_COLS - 1 : cur_x - 1;
        back_y = (cur_x != 0) ? cur_y : ((cur_y == 0) ? SCR_ROWS - 1 : cur_y - 1);
        issue(tts_pkg::OP_GET, $urandom, back_x, back_y);
        repeat ($urandom_range(0, 3)) begin
          issue(tts_pkg::OP_GET, $urandom, $urandom_range(0, SCR_COLS - 1),
                $urandom_range(0, SCR_ROWS - 1));
        end
      end else if (pick < 15) begin
        issue(tts_pkg::OP_SET_SHOWN, $urandom_range(0, 1) ? 0 : $urandom_range(0, 255),
              $urandom, $urandom);
      end else begin
        // Noise: any opcode but clear, every field random
        repeat ($urandom_range(1, 5)) begin
          issue(tts_pkg::opcode_t'($urandom_range(1, 7)), $urandom, $urandom, $urandom);
        end
      end
    end
  endtask

  // Receiver holds off while commands keep coming, then a full drain
  task automatic test_backpressure();
    src_idle_en   = 1'b0;
    long_hold_req = 1'b1;
    repeat (30) begin
      issue($urandom_range(0, 1) ? tts_pkg::OP_PUT : tts_pkg::OP_GET, $urandom,
            $urandom_range(0, SCR_COLS), $urandom_range(0, SCR_ROWS));
    end
    drain_reports();
  endtask

  // Back-to-back stream with no idling on either side
  task automatic test_streaming();
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    repeat (150) begin
      issue($urandom_range(0, 2) != 0 ? tts_pkg::OP_PUT : tts_pkg::OP_GET, $urandom,
            $urandom_range(0, SCR_COLS - 1), $urandom_range(0, SCR_ROWS - 1));
    end
  endtask

  initial begin
    foreach (screen_image[i]) screen_image[i] = tts_pkg::SPACE_CODE;
    cur_x     = 0;
    cur_y     = 0;
    shown_now = 1'b0;
    quiet_cycles = 0;
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    long_hold_req = 1'b0;
    rst                <= 1'b1;
    cmd_ch.valid       <= 1'b0;
    cmd_ch.opcode      <= tts_pkg::OP_CLEAR;
    cmd_ch.char_or_pos <= '0;
    cmd_ch.read_col    <= '0;
    cmd_ch.read_row    <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_after_reset();
    test_cursor_setup();
    test_translation();
    test_wrap_to_top();
    test_offscreen_and_spare();
    test_clear();
    test_backpressure();
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    test_random_sessions(sent_cmds + RANDOM_CMDS);
    test_streaming();

    drain_reports();
    repeat (4) @(posedge clk);

    $display("Sent %0d commands: %0d puts (%0d row wraps, %0d top wraps), %0d gets",
             sent_cmds, n_puts, n_line_wraps, n_top_wraps, n_gets);
    $display("%0d off-screen gets, %0d clears, %0d long hold-offs, %0d results checked",
             n_offscreen, n_clears, n_holds, checked);
    if (faults == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
